/* design/led_matrix_text_scroller_top_macros.svh */
// Assertion helpers shared by the scroller RTL.
`ifndef LED_MATRIX_TEXT_SCROLLER_TOP_MACROS_SVH
`define LED_MATRIX_TEXT_SCROLLER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define LMTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LMTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/lmts_pkg.sv */
`default_nettype none

package lmts_pkg;

    localparam int GLYPH_DEPTH   = 256;
    localparam int MATRIX_WIDTH  = 32;
    localparam int MATRIX_HEIGHT = 8;

    localparam int GLYPH_AW  = $clog2(GLYPH_DEPTH);
    localparam int GLYPH_W   = 64;
    localparam int INDEX_W   = 8;
    localparam int ROW_W     = $clog2(MATRIX_HEIGHT);
    localparam int POS_W     = 9;
    localparam int CMP_W     = 11;
    localparam int TAIL_W    = $clog2(MATRIX_WIDTH + 1);
    localparam int COL_OUT_W = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int S_TDATA_W = 88;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 9;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_START   = 2'd1,
        CMD_STEP    = 2'd2,
        CMD_REFRESH = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                 cmd;
        logic [INDEX_W-1:0]   glyph_index;
        logic [GLYPH_W-1:0]   glyph;
        logic [POS_W-1:0]     text_length;
    } t_cmd_item;

    typedef struct packed {
        logic [COL_OUT_W-1:0]     column_bits;
        logic [MATRIX_HEIGHT-1:0] row_select;
        logic                     last_row;
        logic                     scroll_done;
    } t_row_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_NEXT,
        ST_SHIFT,
        ST_EMIT
    } t_back_state;

endpackage

`default_nettype wire

/* design/lmts_ram.sv */
`default_nettype none

module lmts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* design/lmts_front.sv */
`default_nettype none
`include "led_matrix_text_scroller_top_macros.svh"

module lmts_front
    import lmts_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    input  wire logic [S_TUSER_W-1:0] i_s_tuser,
    output logic                      o_q_valid,
    output t_cmd_item                 o_q_item,
    input  wire logic                 i_q_pop
);

    t_cmd_item         dec_item;
    logic              idx_ok;
    logic              enq;
    t_cmd_item         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    // classify: split the transfer into fields, drop loads past the store
    always_comb begin
        dec_item.cmd         = t_cmd'(i_s_tuser);
        dec_item.glyph_index = i_s_tdata[INDEX_W-1:0];
        dec_item.glyph       = i_s_tdata[INDEX_W +: GLYPH_W];
        dec_item.text_length = i_s_tdata[INDEX_W + GLYPH_W +: POS_W];
        idx_ok = CMP_W'(dec_item.glyph_index) < CMP_W'(GLYPH_DEPTH);
    end

    assign o_s_tready = r_count != QCNT_W'(QUEUE_DEPTH);
    assign enq = i_s_tvalid && o_s_tready && ((dec_item.cmd != CMD_LOAD) || idx_ok);
    assign o_q_valid = r_count != '0;
    assign o_q_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_mem[r_wr_ptr] <= dec_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (enq) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({enq, i_q_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `LMTS_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, i_q_pop, r_count != '0, "pop from empty queue")
    `LMTS_ASSERT_NEXT(a_enq_visible, i_clk, i_rst_n, enq && !i_q_pop, o_q_valid, "queued command lost")

endmodule

`default_nettype wire

/* design/lmts_back.sv */
`default_nettype none
`include "led_matrix_text_scroller_top_macros.svh"

module lmts_back
    import lmts_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_q_valid,
    input  wire t_cmd_item i_q_item,
    output logic           o_q_pop,
    output logic           o_m_valid,
    input  wire logic      i_m_tready,
    output t_row_word      o_m_word
);

    t_back_state r_state;
    t_back_state n_state;

    logic [MATRIX_WIDTH-1:0] r_frame [MATRIX_HEIGHT];
    logic [MATRIX_WIDTH-1:0] n_frame [MATRIX_HEIGHT];
    logic [POS_W-1:0]        r_pos, n_pos;
    logic [2:0]              r_col, n_col;
    logic [TAIL_W-1:0]       r_tail, n_tail;
    logic                    r_ended, n_ended;
    logic                    r_active, n_active;
    logic [POS_W-1:0]        r_len, n_len;
    logic [ROW_W-1:0]        r_row;
    logic [GLYPH_W-1:0]      r_glyph_cur;
    t_row_word               r_out;
    logic                    r_out_valid;

    logic                    ram_we;
    logic [GLYPH_AW-1:0]     ram_raddr;
    logic [GLYPH_W-1:0]      ram_rdata;
    logic [POS_W-1:0]        pos_next;
    logic                    cur_blank;
    logic                    next_blank;
    logic [7:0]              next_row4;
    logic                    end_hit;
    logic                    out_free;
    logic                    emit_load;
    logic                    do_start;
    logic                    do_shift;

    assign pos_next = r_pos + 1'b1;
    assign cur_blank = (r_pos >= r_len) || (CMP_W'(r_pos) >= CMP_W'(GLYPH_DEPTH));
    assign next_blank = ((CMP_W'(r_pos) + CMP_W'(1)) >= CMP_W'(r_len))
                     || ((CMP_W'(r_pos) + CMP_W'(1)) >= CMP_W'(GLYPH_DEPTH));
    assign next_row4 = next_blank ? 8'h00 : ram_rdata[32 +: 8];
    assign end_hit = (r_pos >= r_len) || ((r_glyph_cur[32 +: 8] == 8'h00) && (next_row4 == 8'h00));
    assign out_free = !r_out_valid || i_m_tready;

    lmts_ram #(
        .WIDTH (GLYPH_W),
        .DEPTH (GLYPH_DEPTH)
    ) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (GLYPH_AW'(i_q_item.glyph_index)),
        .i_wdata (i_q_item.glyph),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_item.cmd)
                        CMD_STEP:    n_state = r_active ? ST_RD_NEXT : ST_EMIT;
                        CMD_REFRESH: n_state = ST_EMIT;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RD_NEXT: n_state = ST_SHIFT;
            ST_SHIFT:   n_state = ST_EMIT;
            ST_EMIT: begin
                if (emit_load && (r_row == ROW_W'(MATRIX_HEIGHT - 1))) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_q_pop   = 1'b0;
        ram_we    = 1'b0;
        ram_raddr = GLYPH_AW'(r_pos);
        emit_load = 1'b0;
        do_start  = 1'b0;
        do_shift  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_q_pop  = i_q_valid;
                ram_we   = i_q_valid && (i_q_item.cmd == CMD_LOAD);
                do_start = i_q_valid && (i_q_item.cmd == CMD_START);
            end
            ST_RD_NEXT: ram_raddr = GLYPH_AW'(pos_next);
            ST_SHIFT:   do_shift  = 1'b1;
            ST_EMIT:    emit_load = out_free;
            default: begin
                o_q_pop = 1'b0;
            end
        endcase
    end

    // scroll state update: start rearms, shift moves one column
    always_comb begin
        n_pos    = r_pos;
        n_col    = r_col;
        n_tail   = r_tail;
        n_ended  = r_ended;
        n_active = r_active;
        n_len    = r_len;
        for (int r = 0; r < MATRIX_HEIGHT; r++) begin
            n_frame[r] = r_frame[r];
        end
        if (do_start) begin
            for (int r = 0; r < MATRIX_HEIGHT; r++) begin
                n_frame[r] = '0;
            end
            n_len    = i_q_item.text_length;
            n_pos    = '0;
            n_col    = '0;
            n_tail   = '0;
            n_ended  = 1'b0;
            n_active = 1'b1;
        end else if (do_shift) begin
            for (int r = 0; r < MATRIX_HEIGHT; r++) begin
                n_frame[r] = {r_frame[r][MATRIX_WIDTH-2:0],
                              !r_ended && r_glyph_cur[8*r + 7 - int'(r_col)]};
            end
            n_ended = r_ended || end_hit;
            if (n_ended) begin
                n_tail = r_tail + 1'b1;
                if ((r_tail + 1'b1) >= TAIL_W'(MATRIX_WIDTH)) begin
                    n_active = 1'b0;
                end
            end else begin
                n_col = r_col + 1'b1;
                if (r_col == 3'd7) begin
                    n_pos = pos_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_col       <= '0;
            r_tail      <= '0;
            r_ended     <= 1'b0;
            r_active    <= 1'b0;
            r_len       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
            for (int r = 0; r < MATRIX_HEIGHT; r++) begin
                r_frame[r] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_col    <= n_col;
            r_tail   <= n_tail;
            r_ended  <= n_ended;
            r_active <= n_active;
            r_len    <= n_len;
            for (int r = 0; r < MATRIX_HEIGHT; r++) begin
                r_frame[r] <= n_frame[r];
            end
            if (emit_load) begin
                r_row       <= r_row + 1'b1;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RD_NEXT) begin
            r_glyph_cur <= cur_blank ? '0 : ram_rdata;
        end
        if (emit_load) begin
            r_out.column_bits <= COL_OUT_W'(r_frame[r_row]);
            r_out.row_select  <= MATRIX_HEIGHT'(1) << (ROW_W'(MATRIX_HEIGHT - 1) - r_row);
            r_out.last_row    <= r_row == ROW_W'(MATRIX_HEIGHT - 1);
            r_out.scroll_done <= r_ended && !r_active;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_word  = r_out;

    `LMTS_ASSERT_IMPL(a_last_is_row7, i_clk, i_rst_n, r_out_valid && r_out.last_row, r_out.row_select == MATRIX_HEIGHT'(1), "last row word not on bottom row")
    `LMTS_ASSERT_IMPL(a_tail_bound, i_clk, i_rst_n, r_active, r_tail < TAIL_W'(MATRIX_WIDTH), "tail count past matrix width while active")
    `LMTS_ASSERT_IMPL(a_stop_needs_end, i_clk, i_rst_n, $fell(r_active), r_ended, "scroll stopped without text end")
    `LMTS_ASSERT_NEXT(a_fetch_then_shift, i_clk, i_rst_n, r_state == ST_RD_NEXT, r_state == ST_SHIFT, "glyph fetch not followed by shift")

endmodule

`default_nettype wire

/* design/led_matrix_text_scroller_top.sv */
// Channel   Dir  tdata                               tuser                   tlast
// s_axis    in   index, glyph rows 0..7, length      cmd                     -
// m_axis    out  column_bits                         row_select, scroll_done last_row
//
// Load and start complete in the back end's idle state; refresh, and a step
// while no scroll runs, go straight to emit; a step that shifts passes read-next
// and shift, as the single glyph RAM read port fetches current and next glyph.
// Row words leave one per cycle through the output register when not stalled.
// Reset (synchronous, active low) clears the queue, scroll state and frame;
// the glyph store is not cleared. A two-entry command queue lets s_axis take
// up to two transfers while m_axis stalls.
`default_nettype none

module led_matrix_text_scroller_top
    import lmts_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // [7:0] glyph_index, [15:8]..[71:64] glyph_row0..glyph_row7,
    // [80:72] text_length, [87:81] zero
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] cmd
    input  wire logic [S_TUSER_W-1:0] s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [31:0] column_bits
    output logic [M_TDATA_W-1:0]      m_axis_tdata,
    // [7:0] row_select, [8] scroll_done
    output logic [M_TUSER_W-1:0]      m_axis_tuser,
    // last_row
    output logic                      m_axis_tlast
);

    logic      q_valid;
    t_cmd_item q_item;
    logic      q_pop;
    t_row_word m_word;

    // front end: take transfers, classify, queue
    lmts_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    // back end: glyph store, frame shift, row word emission
    lmts_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_item   (q_item),
        .o_q_pop    (q_pop),
        .o_m_valid  (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_word   (m_word)
    );

    // pack the row word onto the master side
    assign m_axis_tdata = M_TDATA_W'(m_word.column_bits);
    assign m_axis_tuser = {m_word.scroll_done, m_word.row_select};
    assign m_axis_tlast = m_word.last_row;

endmodule

`default_nettype wire
